### hdl/chte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg: shared constants and types for the chained hash table engine
// Holds table sizes, operation and status codes, hash constants and the
// layouts of the bucket head and pool slot memory words.
// ----------------------------------------------------------------------------
package chte_pkg;

    // Table geometry.
    localparam int BUCKET_BITS = 10;
    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int POOL_SLOTS  = 16384;
    localparam int SLOT_AW     = $clog2(POOL_SLOTS);
    localparam int CNT_W       = 15;
    localparam int IB_W        = 4;
    localparam int SHIFT_W     = $clog2(BUCKET_BITS + 1);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] FUNC_FETCH  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Result status codes carried on the output tuser.
    localparam logic [2:0] STAT_HIT       = 3'd0;
    localparam logic [2:0] STAT_MISS      = 3'd1;
    localparam logic [2:0] STAT_INSERTED  = 3'd2;
    localparam logic [2:0] STAT_UPDATED   = 3'd3;
    localparam logic [2:0] STAT_DELETED   = 3'd4;
    localparam logic [2:0] STAT_DEL_MISS  = 3'd5;
    localparam logic [2:0] STAT_POOL_FULL = 3'd6;

    // Finalizer constants.
    localparam logic [63:0] HASH_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] HASH_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int          HASH_SHIFT = 33;

    // Bucket head word: chain present flag and pointer to the newest slot.
    typedef struct packed {
        logic               valid;
        logic [SLOT_AW-1:0] ptr;
    } head_word_t;

    // Pool slot word: link to the next older slot, value and key.
    typedef struct packed {
        logic               lvalid;
        logic [SLOT_AW-1:0] link;
        logic [VAL_W-1:0]   value;
        logic [KEY_W-1:0]   key;
    } slot_word_t;

endpackage
`default_nettype wire

### hdl/chte_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chte_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
module chte_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [1 << ADDR_W];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hdl/chte_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chte_hash: pipelined 64-bit finalizer
// Each 64x64 product (low half) is built from three 32x32 partial products,
// registered before they are summed.
// ----------------------------------------------------------------------------
module chte_hash
    import chte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] key,
    output logic             done,
    output logic [63:0]      hash
);

    logic [4:0]  vld_reg;
    logic [63:0] x1_reg;
    logic [63:0] p0a_reg;
    logic [31:0] p1a_reg;
    logic [31:0] p2a_reg;
    logic [63:0] x3_reg;
    logic [63:0] p0b_reg;
    logic [31:0] p1b_reg;
    logic [31:0] p2b_reg;
    logic [63:0] h_reg;
    logic [63:0] y1;
    logic [63:0] y2;

    // Stage valid chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    // Sums of the partial products.
    assign y1 = p0a_reg + {p1a_reg + p2a_reg, 32'd0};
    assign y2 = p0b_reg + {p1b_reg + p2b_reg, 32'd0};

    // Datapath stages.
    always_ff @(posedge aclk) begin
        x1_reg  <= key ^ (key >> HASH_SHIFT);
        p0a_reg <= x1_reg[31:0] * HASH_C1[31:0];
        p1a_reg <= 32'(x1_reg[63:32] * HASH_C1[31:0]);
        p2a_reg <= 32'(x1_reg[31:0] * HASH_C1[63:32]);
        x3_reg  <= y1 ^ (y1 >> HASH_SHIFT);
        p0b_reg <= x3_reg[31:0] * HASH_C2[31:0];
        p1b_reg <= 32'(x3_reg[63:32] * HASH_C2[31:0]);
        p2b_reg <= 32'(x3_reg[31:0] * HASH_C2[63:32]);
        h_reg   <= y2 ^ (y2 >> HASH_SHIFT);
    end

    assign done = vld_reg[4];
    assign hash = h_reg;

endmodule
`default_nettype wire

### hdl/chained_hash_table_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine: key-value store with separately chained buckets
// Requests enter on the s_ stream (tuser = operation, tdata = key and value,
// tlast = end of batch); one result per request leaves on the m_ stream.
// ----------------------------------------------------------------------------
// Usage:
//   After reset the engine sweeps all 1024 buckets of the head memory, one
//   bucket per cycle; s_tready stays low until that pass is done.
//   cfg_valid/cfg_data write index_bits at any time the engine is idle.
//   One request is processed at a time. A request passes through the hash
//   pipeline, the bucket head read, one slot memory read per chain entry
//   examined and a final step that does any update and posts the result;
//   func 3 skips straight to that final step. The chain walk through the
//   single-port-read slot memory sets the pace.
//   The result sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls, the next request finishes its walk
//   and then holds, with no memory written, until the output slot frees.
// ----------------------------------------------------------------------------
module chained_hash_table_engine
    import chte_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_data,   // index_bits
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,    // req_key[63:0], req_value[127:64]
    input  wire logic [1:0]   s_tuser,    // func[1:0]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,    // found_value[63:0], probe_count[78:64],
                                          // live_entries[93:79], zero fill
    output logic [2:0]        m_tuser,    // status[2:0]
    output logic              m_tlast
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH   = 3'd2;
    localparam logic [2:0] ST_HEAD   = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;

    localparam int HEAD_W = $bits(head_word_t);
    localparam int SLOT_W = $bits(slot_word_t);

    logic [2:0]             state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_reg, clr_next;
    logic [IB_W-1:0]        ib_reg;
    logic [1:0]             func_reg, func_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VAL_W-1:0]       val_reg, val_next;
    logic                   last_reg, last_next;
    logic [BUCKET_BITS-1:0] bucket_reg, bucket_next;
    head_word_t             head_reg, head_next;
    logic [SLOT_AW-1:0]     cur_reg, cur_next;
    logic [SLOT_AW-1:0]     prev_reg, prev_next;
    logic                   have_prev_reg, have_prev_next;
    logic                   hit_reg, hit_next;
    slot_word_t             cur_word_reg, cur_word_next;
    slot_word_t             prev_word_reg, prev_word_next;
    logic [CNT_W-1:0]       probe_reg, probe_next;
    logic [CNT_W-1:0]       free_reg, free_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   mv_reg, mv_next;
    logic [95:0]            md_reg, md_next;
    logic [2:0]             mu_reg, mu_next;
    logic                   ml_reg, ml_next;

    logic                   hash_start;
    logic                   hash_done;
    logic [63:0]            hash_val;
    logic [IB_W-1:0]        ib_eff;
    logic [SHIFT_W-1:0]     ib_shift;
    logic [BUCKET_BITS-1:0] bucket_calc;

    logic                   hb_we, hb_re;
    logic [BUCKET_BITS-1:0] hb_waddr, hb_raddr;
    head_word_t             hb_wdata;
    logic [HEAD_W-1:0]      hb_rbits;
    head_word_t             hb_rdata;

    logic                   sl_we, sl_re;
    logic [SLOT_AW-1:0]     sl_waddr, sl_raddr;
    slot_word_t             sl_wdata;
    logic [SLOT_W-1:0]      sl_rbits;
    slot_word_t             sl_rdata;

    logic                   s_fire;
    logic                   out_free;
    logic [2:0]             res_status;
    logic [VAL_W-1:0]       res_found;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ib_reg <= IB_W'(BUCKET_BITS);
        end else if (cfg_valid) begin
            ib_reg <= cfg_data;
        end
    end

    // Bucket index from the top hash bits, with the width clamped.
    always_comb begin
        if (ib_reg == '0) begin
            ib_eff = IB_W'(1);
        end else if (ib_reg > IB_W'(BUCKET_BITS)) begin
            ib_eff = IB_W'(BUCKET_BITS);
        end else begin
            ib_eff = ib_reg;
        end
        ib_shift    = SHIFT_W'(BUCKET_BITS) - SHIFT_W'(ib_eff);
        bucket_calc = hash_val[63 -: BUCKET_BITS] >> ib_shift;
    end

    chte_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (key_next),
        .done    (hash_done),
        .hash    (hash_val)
    );

    chte_ram #(.WIDTH(HEAD_W), .ADDR_W(BUCKET_BITS)) u_head_ram (
        .aclk  (aclk),
        .we    (hb_we),
        .waddr (hb_waddr),
        .wdata (hb_wdata),
        .re    (hb_re),
        .raddr (hb_raddr),
        .rdata (hb_rbits)
    );
    assign hb_rdata = head_word_t'(hb_rbits);

    chte_ram #(.WIDTH(SLOT_W), .ADDR_W(SLOT_AW)) u_slot_ram (
        .aclk  (aclk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .re    (sl_re),
        .raddr (sl_raddr),
        .rdata (sl_rbits)
    );
    assign sl_rdata = slot_word_t'(sl_rbits);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;

    // Result status and value for the request in the decide step.
    always_comb begin
        res_found = '0;
        unique case (func_reg)
            FUNC_FETCH: begin
                res_status = hit_reg ? STAT_HIT : STAT_MISS;
                if (hit_reg) begin
                    res_found = cur_word_reg.value;
                end
            end
            FUNC_INSERT: begin
                if (hit_reg) begin
                    res_status = STAT_UPDATED;
                end else if (free_reg >= CNT_W'(POOL_SLOTS)) begin
                    res_status = STAT_POOL_FULL;
                end else begin
                    res_status = STAT_INSERTED;
                end
            end
            FUNC_DELETE: res_status = hit_reg ? STAT_DELETED : STAT_DEL_MISS;
            default:     res_status = STAT_MISS;
        endcase
    end

    // Request sequencer: clearing pass, then hash, head read, chain walk, update and result.
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        bucket_next    = bucket_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        hit_next       = hit_reg;
        cur_word_next  = cur_word_reg;
        prev_word_next = prev_word_reg;
        probe_next     = probe_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        mv_next        = mv_reg && !m_tready;
        md_next        = md_reg;
        mu_next        = mu_reg;
        ml_next        = ml_reg;
        hash_start     = 1'b0;
        hb_we          = 1'b0;
        hb_waddr       = bucket_reg;
        hb_wdata       = '0;
        hb_re          = 1'b0;
        hb_raddr       = bucket_calc;
        sl_we          = 1'b0;
        sl_waddr       = cur_reg;
        sl_wdata       = cur_word_reg;
        sl_re          = 1'b0;
        sl_raddr       = head_reg.ptr;

        unique case (state_reg)
            ST_CLEAR: begin
                hb_we    = 1'b1;
                hb_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    func_next      = s_tuser;
                    key_next       = s_tdata[63:0];
                    val_next       = s_tdata[127:64];
                    last_next      = s_tlast;
                    probe_next     = '0;
                    hit_next       = 1'b0;
                    have_prev_next = 1'b0;
                    if (s_tuser == FUNC_FETCH || s_tuser == FUNC_INSERT ||
                        s_tuser == FUNC_DELETE) begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    hb_re       = 1'b1;
                    bucket_next = bucket_calc;
                    state_next  = ST_HEAD;
                end
            end
            ST_HEAD: begin
                head_next = hb_rdata;
                if (hb_rdata.valid) begin
                    sl_re      = 1'b1;
                    sl_raddr   = hb_rdata.ptr;
                    cur_next   = hb_rdata.ptr;
                    probe_next = CNT_W'(1);
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_WALK: begin
                if (sl_rdata.key == key_reg) begin
                    hit_next      = 1'b1;
                    cur_word_next = sl_rdata;
                    state_next    = ST_DECIDE;
                end else begin
                    prev_next      = cur_reg;
                    prev_word_next = sl_rdata;
                    have_prev_next = 1'b1;
                    if (sl_rdata.lvalid && probe_reg < CNT_W'(POOL_SLOTS)) begin
                        sl_re      = 1'b1;
                        sl_raddr   = sl_rdata.link;
                        cur_next   = sl_rdata.link;
                        probe_next = probe_reg + 1'b1;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    unique case (func_reg)
                        FUNC_INSERT: begin
                            if (hit_reg) begin
                                sl_we          = 1'b1;
                                sl_wdata.value = val_reg;
                            end else if (free_reg < CNT_W'(POOL_SLOTS)) begin
                                sl_we           = 1'b1;
                                sl_waddr        = free_reg[SLOT_AW-1:0];
                                sl_wdata.key    = key_reg;
                                sl_wdata.value  = val_reg;
                                sl_wdata.link   = head_reg.ptr;
                                sl_wdata.lvalid = head_reg.valid;
                                hb_we           = 1'b1;
                                hb_wdata.valid  = 1'b1;
                                hb_wdata.ptr    = free_reg[SLOT_AW-1:0];
                                free_next       = free_reg + 1'b1;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        FUNC_DELETE: begin
                            if (hit_reg) begin
                                if (have_prev_reg) begin
                                    sl_we           = 1'b1;
                                    sl_waddr        = prev_reg;
                                    sl_wdata        = prev_word_reg;
                                    sl_wdata.link   = cur_word_reg.link;
                                    sl_wdata.lvalid = cur_word_reg.lvalid;
                                end else begin
                                    hb_we          = 1'b1;
                                    hb_wdata.valid = cur_word_reg.lvalid;
                                    hb_wdata.ptr   = cur_word_reg.link;
                                end
                                if (count_reg != '0) begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    mv_next    = 1'b1;
                    mu_next    = res_status;
                    ml_next    = last_reg;
                    md_next    = {2'b00, count_next, probe_reg, res_found};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            free_reg  <= '0;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        last_reg      <= last_next;
        bucket_reg    <= bucket_next;
        head_reg      <= head_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        hit_reg       <= hit_next;
        cur_word_reg  <= cur_word_next;
        prev_word_reg <= prev_word_next;
        probe_reg     <= probe_next;
        md_reg        <= md_next;
        mu_reg        <= mu_next;
        ml_reg        <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

`ifndef SYNTHESIS
    // No request is taken while the bucket memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request accepted during clearing pass");

    // Live keys never outnumber the slots handed out.
    a_count_le_free: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= free_reg)
        else $error("live key count exceeds allocated slots");

    // Only a fetch hit carries a nonzero value.
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_HIT) |-> (m_tdata[63:0] == '0))
        else $error("found value set on a result that is not a hit");

    // A new result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
